>>> hdl/ddtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddtt_pkg
// Shared types and constants for the drag-and-drop transfer tracker.
// ----------------------------------------------------------------------------
package ddtt_pkg;

   localparam int SectorW = 24;
   localparam int SecExtW = SectorW + 1;
   localparam int BytesW  = 24;

   localparam logic [SecExtW-1:0] INV_SECTOR = 25'h1FF_FFFF;
   localparam logic [8:0]         INV_FILE   = 9'h100;
   localparam logic [BytesW-1:0]  MAX_BYTES  = 24'hFF_FFFF;
   localparam logic [2:0]         KIND_NONE  = 3'd0;

   // transfer status / fail codes
   localparam logic [4:0] ST_OK           = 5'd0;
   localparam logic [4:0] ST_DONE         = 5'd1;
   localparam logic [4:0] ST_DONE_OR_CONT = 5'd2;
   localparam logic [4:0] ST_IN_PROGRESS  = 5'd3;
   localparam logic [4:0] ST_XFER_ERROR   = 5'd4;

   typedef enum logic [1:0] {
      OP_FILE_INFO    = 2'd0,
      OP_OPEN_RESULT  = 2'd1,
      OP_SECTOR_CHECK = 2'd2,
      OP_WRITE_RESULT = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [7:0]         file_id;
      logic [SectorW-1:0] sector;
      logic               sector_valid;
      logic [23:0]        size_bytes;
      logic [2:0]         stream_type;
      logic [7:0]         sector_count;
      logic [4:0]         op_status;
   } req_item_type;

   typedef struct packed {
      logic               accept;
      logic               need_identify;
      logic [4:0]         fail_code;
      logic               finished;
      logic               remount_request;
      logic               stream_is_open;
   } rsp_item_type;

   typedef struct packed {
      logic [8:0]         file_handle;
      logic [SecExtW-1:0] first_sector;
      logic [SecExtW-1:0] next_sector;
      logic [BytesW-1:0]  bytes_done;
      logic [23:0]        expected_size;
      logic [4:0]         transfer_status;
      logic               finished_flag;
      logic               open_flag;
      logic [2:0]         stream_kind;
      logic [4:0]         last_fail;
   } track_state_type;

   localparam track_state_type STATE_RESET = '{
      file_handle:     INV_FILE,
      first_sector:    INV_SECTOR,
      next_sector:     INV_SECTOR,
      bytes_done:      '0,
      expected_size:   '0,
      transfer_status: ST_OK,
      finished_flag:   1'b0,
      open_flag:       1'b0,
      stream_kind:     KIND_NONE,
      last_fail:       ST_OK
   };

endpackage

>>> hdl/ddtt_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddtt_update
// Next-state and result logic for one tracker event.
// ----------------------------------------------------------------------------
module ddtt_update
   import ddtt_pkg::*;
#(
   parameter int SECTOR_BYTES = 512
) (
   input  track_state_type cur_state,
   input  req_item_type    item,
   output track_state_type nxt_state,
   output rsp_item_type    result
);

   localparam int AddW = 8 + $clog2(SECTOR_BYTES + 1);
   localparam int SumW = ((AddW > BytesW) ? AddW : BytesW) + 1;

   opcode_type         op;
   logic [SecExtW-1:0] sec_ext;
   logic [SecExtW-1:0] start_sec;
   logic               in_order;
   logic [AddW-1:0]    add_bytes;
   logic [SumW-1:0]    sum_bytes;
   logic               do_check;
   logic               full;
   logic               nonzero;
   logic               accept;
   logic               ident;
   logic               remount;

   assign op        = opcode_type'(item.opcode);
   assign sec_ext   = {1'b0, item.sector};
   assign in_order  = cur_state.open_flag && (sec_ext >= cur_state.first_sector)
                      && (sec_ext == cur_state.next_sector);
   assign add_bytes = AddW'(item.sector_count) * AddW'(SECTOR_BYTES);
   assign sum_bytes = SumW'(cur_state.bytes_done) + SumW'(add_bytes);

   always_comb begin
      nxt_state = cur_state;
      start_sec = INV_SECTOR;
      do_check  = 1'b0;
      accept    = 1'b0;
      ident     = 1'b0;
      remount   = 1'b0;
      full      = 1'b0;
      nonzero   = 1'b0;

      // a finished transfer ignores everything
      if (!cur_state.finished_flag) begin
         unique case (op)
            OP_FILE_INFO: begin
               start_sec = item.sector_valid ? sec_ext : INV_SECTOR;
               if (cur_state.file_handle == INV_FILE)
                  nxt_state.file_handle = {1'b0, item.file_id};
               if (cur_state.first_sector == INV_SECTOR)
                  nxt_state.first_sector = start_sec;
               if (cur_state.stream_kind == KIND_NONE)
                  nxt_state.stream_kind = item.stream_type;
               if (item.size_bytes < cur_state.expected_size)
                  nxt_state.transfer_status = ST_XFER_ERROR;
               if (item.sector_valid && (start_sec != nxt_state.first_sector))
                  nxt_state.transfer_status = ST_XFER_ERROR;
               if (item.stream_type != nxt_state.stream_kind)
                  nxt_state.transfer_status = ST_XFER_ERROR;
               if (item.size_bytes > cur_state.expected_size)
                  nxt_state.expected_size = item.size_bytes;
               do_check = 1'b1;
               remount  = 1'b1;
            end
            OP_OPEN_RESULT: begin
               if (!cur_state.open_flag) begin
                  if (cur_state.first_sector == INV_SECTOR)
                     nxt_state.first_sector = sec_ext;
                  if (cur_state.stream_kind == KIND_NONE)
                     nxt_state.stream_kind = item.stream_type;
                  if (sec_ext != nxt_state.first_sector)
                     nxt_state.transfer_status = ST_XFER_ERROR;
                  if (item.stream_type != nxt_state.stream_kind)
                     nxt_state.transfer_status = ST_XFER_ERROR;
                  if (nxt_state.transfer_status == ST_OK)
                     nxt_state.transfer_status = item.op_status;
                  if (item.op_status == ST_OK) begin
                     nxt_state.next_sector = sec_ext;
                     nxt_state.open_flag   = 1'b1;
                  end
                  do_check = 1'b1;
                  remount  = 1'b1;
               end
            end
            OP_SECTOR_CHECK: begin
               ident  = !cur_state.open_flag;
               accept = in_order;
            end
            OP_WRITE_RESULT: begin
               if (in_order) begin
                  // byte count saturates
                  nxt_state.bytes_done = (sum_bytes > SumW'(MAX_BYTES)) ? MAX_BYTES
                                         : sum_bytes[BytesW-1:0];
                  nxt_state.next_sector     = sec_ext + SecExtW'(item.sector_count);
                  nxt_state.transfer_status = item.op_status;
                  do_check = 1'b1;
                  remount  = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (do_check) begin
         full    = nxt_state.bytes_done >= nxt_state.expected_size;
         nonzero = nxt_state.expected_size != '0;
         priority if (nxt_state.transfer_status == ST_DONE && full && nonzero) begin
            nxt_state.last_fail     = ST_OK;
            nxt_state.finished_flag = 1'b1;
         end else if (nxt_state.transfer_status == ST_DONE_OR_CONT && full && nonzero) begin
            nxt_state.last_fail = ST_OK;
         end else if (nxt_state.transfer_status <= ST_DONE_OR_CONT) begin
            nxt_state.last_fail = ST_IN_PROGRESS;
         end else begin
            nxt_state.last_fail     = nxt_state.transfer_status;
            nxt_state.finished_flag = 1'b1;
         end
      end
   end

   assign result = '{
      accept:          accept,
      need_identify:   ident,
      fail_code:       nxt_state.last_fail,
      finished:        nxt_state.finished_flag,
      remount_request: remount,
      stream_is_open:  nxt_state.open_flag
   };

endmodule

>>> hdl/drag_drop_transfer_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drag_drop_transfer_tracker
// Follows one drag-and-drop programming transfer: file info, stream open,
// sector checks and sector writes, giving fail code, finish and remount.
//
//   channel  direction  handshake              payload
//   req_*    in         req_valid / req_stall  opcode, file_id, sector, ...
//   rsp_*    out        rsp_valid / rsp_stall  accept, fail_code, finished, ...
//
// one item per cycle unless the result is stalled; an item passes the input
// register, then the state update and result register in a single pass
// the tracker state sits in one register updated as the item leaves the
// input register, so back-to-back items see each other's effect
// reset (synchronous, active high) clears state and both valid flags
// a stalled result holds the input register, which then stalls req
// ----------------------------------------------------------------------------
module drag_drop_transfer_tracker
   import ddtt_pkg::*;
#(
   parameter int SECTOR_BYTES = 512
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_file_id,
   input  logic [23:0] req_sector,
   input  logic        req_sector_valid,
   input  logic [23:0] req_size_bytes,
   input  logic [2:0]  req_stream_type,
   input  logic [7:0]  req_sector_count,
   input  logic [4:0]  req_op_status,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accept,
   output logic        rsp_need_identify,
   output logic [4:0]  rsp_fail_code,
   output logic        rsp_finished,
   output logic        rsp_remount_request,
   output logic        rsp_stream_is_open
);

   req_item_type    item_ff,       item_in;
   logic            item_valid_ff, item_valid_in;
   rsp_item_type    rsp_ff,        rsp_in;
   logic            rsp_valid_ff,  rsp_valid_in;
   track_state_type state_ff,      state_in;
   track_state_type state_calc;
   logic            advance;
   logic            load;

   ddtt_update #(
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_update (
      .cur_state (state_ff),
      .item      (item_ff),
      .nxt_state (state_calc),
      .result    (rsp_in)
   );

   assign advance   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   assign item_in = '{
      opcode:       req_opcode,
      file_id:      req_file_id,
      sector:       req_sector,
      sector_valid: req_sector_valid,
      size_bytes:   req_size_bytes,
      stream_type:  req_stream_type,
      sector_count: req_sector_count,
      op_status:    req_op_status
   };

   assign item_valid_in = load || (item_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);
   assign state_in      = advance ? state_calc : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= STATE_RESET;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         state_ff      <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accept          = rsp_ff.accept;
   assign rsp_need_identify   = rsp_ff.need_identify;
   assign rsp_fail_code       = rsp_ff.fail_code;
   assign rsp_finished        = rsp_ff.finished;
   assign rsp_remount_request = rsp_ff.remount_request;
   assign rsp_stream_is_open  = rsp_ff.stream_is_open;

   // a finished transfer stays finished until reset
   a_finish_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.finished_flag |=> state_ff.finished_flag)
      else $error("finished flag dropped without reset");

   // an accepted sector needs an open stream
   a_accept_open: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accept) |-> (rsp_stream_is_open && !rsp_need_identify))
      else $error("sector accepted while stream closed");

   // sector checks never ask for a remount
   a_accept_no_remount: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !((rsp_accept || rsp_need_identify) && rsp_remount_request))
      else $error("sector check raised remount");

   // the result register only moves when it was empty or taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_ff)))
      else $error("stalled result changed");

endmodule
